// ----- rtl/bpid_pkg.sv -----
// Package for the track classifier: item types, register indexes, constants and the exp2 table.
// Used by bayesian_pid_track_classifier and the testbench; depends on nothing else.
package bpid_pkg;

  // Number of species that take part (2..4; four sets of n-sigma fields exist).
  localparam int unsigned Species     = 4;
  localparam int unsigned FieldLanes  = 4;
  localparam int unsigned DivSteps    = 16;
  localparam int unsigned SumW        = 35;
  localparam int unsigned CfgIdxW     = 3;
  localparam logic [16:0] Log2eQ16    = 17'd94548;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegMinPt     = 3'd0;
  localparam logic [CfgIdxW-1:0] RegMaxPt     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegMinEta    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegMaxEta    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegPriorPion = 3'd4;
  localparam logic [CfgIdxW-1:0] RegPriorKaon = 3'd5;
  localparam logic [CfgIdxW-1:0] RegPriorProt = 3'd6;
  localparam logic [CfgIdxW-1:0] RegPriorElec = 3'd7;

  typedef struct packed {
    logic [15:0]        track_pt;
    logic signed [15:0] track_eta;
    logic               tpc_present;
    logic               tof_present;
    logic signed [15:0] tpc_sigma_pion;
    logic signed [15:0] tpc_sigma_kaon;
    logic signed [15:0] tpc_sigma_proton;
    logic signed [15:0] tpc_sigma_electron;
    logic signed [15:0] tof_sigma_pion;
    logic signed [15:0] tof_sigma_kaon;
    logic signed [15:0] tof_sigma_proton;
    logic signed [15:0] tof_sigma_electron;
  } track_in_t;

  typedef struct packed {
    logic [15:0] prob_pion;
    logic [15:0] prob_kaon;
    logic [15:0] prob_proton;
    logic [15:0] prob_electron;
    logic        no_probability;
  } track_out_t;

  // 2^(-j/16) in Q1.16, for j = 0..16.
  function automatic logic [16:0] exp2_tab(input logic [4:0] j);
    logic [16:0] v;
    unique case (j)
      5'd0:    v = 17'd65536;
      5'd1:    v = 17'd62757;
      5'd2:    v = 17'd60097;
      5'd3:    v = 17'd57549;
      5'd4:    v = 17'd55109;
      5'd5:    v = 17'd52773;
      5'd6:    v = 17'd50535;
      5'd7:    v = 17'd48393;
      5'd8:    v = 17'd46341;
      5'd9:    v = 17'd44376;
      5'd10:   v = 17'd42494;
      5'd11:   v = 17'd40693;
      5'd12:   v = 17'd38968;
      5'd13:   v = 17'd37316;
      5'd14:   v = 17'd35734;
      5'd15:   v = 17'd34219;
      5'd16:   v = 17'd32768;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/bayesian_pid_track_classifier.sv -----
// Bayesian particle identifier: Gaussian likelihoods, priors and normalization.
// Depends on bpid_pkg.
// Throughput: one track per cycle; busy never rises, the pipeline never stalls.
// The normalizing division is a 16-stage restoring divider, one quotient bit a stage.
// Reset clears all valid bits and loads the register defaults; payload is not reset.
module bayesian_pid_track_classifier (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  bpid_pkg::track_in_t             track_in_i,
  input  logic                            cfg_we_i,
  input  logic [bpid_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [15:0]                     cfg_data_i,
  output logic                            done_o,
  output bpid_pkg::track_out_t            result_o
);
  import bpid_pkg::*;

  localparam int unsigned Latency = 26;
  localparam int unsigned L = FieldLanes;

  // Configuration registers.
  logic [15:0]        min_pt_q, max_pt_q;
  logic signed [15:0] min_eta_q, max_eta_q;
  logic [15:0]        prior_q [L];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_pt_q   <= 16'd26;
      max_pt_q   <= 16'd5120;
      min_eta_q  <= -16'sd6144;
      max_eta_q  <= 16'sd6144;
      prior_q[0] <= 16'd32768;
      prior_q[1] <= 16'd6554;
      prior_q[2] <= 16'd3277;
      prior_q[3] <= 16'd1638;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegMinPt:     min_pt_q   <= cfg_data_i;
        RegMaxPt:     max_pt_q   <= cfg_data_i;
        RegMinEta:    min_eta_q  <= cfg_data_i;
        RegMaxEta:    max_eta_q  <= cfg_data_i;
        RegPriorPion: prior_q[0] <= cfg_data_i;
        RegPriorKaon: prior_q[1] <= cfg_data_i;
        RegPriorProt: prior_q[2] <= cfg_data_i;
        RegPriorElec: prior_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Valid bits for stages 0..8, the divider stages and the output.
  logic v_q [9];
  logic dv_q [DivSteps];
  logic out_v_q;

  // Payload registers.
  track_in_t          in0_q;
  logic               tpc1_q, tof1_q, tpc2_q, tpc3_q, tpc4_q, tpc5_q;
  logic [30:0]        sqa1_q [L];
  logic [30:0]        sqb1_q [L];
  logic [31:0]        chi2_q [L];
  logic [31:0]        t3_q   [L];
  logic [16:0]        tab4_q [L];
  logic [23:0]        corr4_q[L];
  logic [4:0]         n4_q   [L];
  logic               z4_q   [L];
  logic [16:0]        lik5_q [L];
  logic [32:0]        w6_q   [L];
  logic [32:0]        w7_q   [L];
  logic [SumW-1:0]    sum7_q;
  logic [SumW-1:0]    rem_q  [DivSteps+1][L];
  logic [15:0]        lq_q   [DivSteps+1][L];
  logic [SumW-1:0]    dsum_q [DivSteps+1];
  logic               nop_q  [DivSteps+1];
  track_out_t         res_q;

  // Per-lane views of the input sigma fields.
  logic signed [15:0] tpc_sig [L];
  logic signed [15:0] tof_sig [L];
  assign tpc_sig[0] = in0_q.tpc_sigma_pion;
  assign tpc_sig[1] = in0_q.tpc_sigma_kaon;
  assign tpc_sig[2] = in0_q.tpc_sigma_proton;
  assign tpc_sig[3] = in0_q.tpc_sigma_electron;
  assign tof_sig[0] = in0_q.tof_sigma_pion;
  assign tof_sig[1] = in0_q.tof_sigma_kaon;
  assign tof_sig[2] = in0_q.tof_sigma_proton;
  assign tof_sig[3] = in0_q.tof_sigma_electron;

  // Kinematic window check on the registered track.
  logic pass0;
  assign pass0 = (in0_q.track_pt >= min_pt_q) && (in0_q.track_pt <= max_pt_q) &&
                 (in0_q.track_eta >= min_eta_q) && (in0_q.track_eta <= max_eta_q);

  // Valid chain.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < 9; s++) v_q[s] <= 1'b0;
      for (int s = 0; s < DivSteps; s++) dv_q[s] <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      v_q[0] <= start && !busy;
      v_q[1] <= v_q[0] && pass0;
      for (int s = 2; s < 9; s++) v_q[s] <= v_q[s-1];
      dv_q[0] <= v_q[8];
      for (int s = 1; s < DivSteps; s++) dv_q[s] <= dv_q[s-1];
      out_v_q <= dv_q[DivSteps-1];
    end
  end

  // Combinational stage logic per lane.
  logic signed [31:0] sqa_d [L];
  logic signed [31:0] sqb_d [L];
  logic [48:0]        tprod_d [L];
  logic [4:0]         k_d [L];
  logic [16:0]        tk_d [L];
  logic [16:0]        tk1_d [L];
  logic [11:0]        tdiff_d [L];
  logic [16:0]        m_d [L];
  logic [SumW-1:0]    sum_d;
  logic [48:0]        num_d [L];

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < L; i++) begin
      sqa_d[i]   = tpc_sig[i] * tpc_sig[i];
      sqb_d[i]   = tof_sig[i] * tof_sig[i];
      tprod_d[i] = chi2_q[i] * Log2eQ16;
      k_d[i]     = {1'b0, t3_q[i][15:12]};
      tk_d[i]    = exp2_tab(k_d[i]);
      tk1_d[i]   = exp2_tab(k_d[i] + 5'd1);
      // Adjacent table entries differ by less than 4096.
      tdiff_d[i] = 12'(tk_d[i] - tk1_d[i]);
      m_d[i]     = tab4_q[i] - {5'd0, corr4_q[i][23:12]};
      sum_d      = sum_d + {{(SumW-33){1'b0}}, w6_q[i]};
      num_d[i]   = {1'b0, w7_q[i], 15'd0} + {15'd0, sum7_q[SumW-1:1]};
    end
  end

  // Likelihood and weight stages.
  always_ff @(posedge clk_i) begin
    if (start && !busy) in0_q <= track_in_i;
    tpc1_q <= in0_q.tpc_present;
    tof1_q <= in0_q.tof_present;
    tpc2_q <= tpc1_q;
    tpc3_q <= tpc2_q;
    tpc4_q <= tpc3_q;
    tpc5_q <= tpc4_q;
    for (int i = 0; i < L; i++) begin
      sqa1_q[i]  <= sqa_d[i][30:0];
      sqb1_q[i]  <= sqb_d[i][30:0];
      chi2_q[i]  <= {1'b0, sqa1_q[i]} + (tof1_q ? {1'b0, sqb1_q[i]} : 32'd0);
      t3_q[i]    <= tprod_d[i][48:17];
      tab4_q[i]  <= tk_d[i];
      corr4_q[i] <= tdiff_d[i] * t3_q[i][11:0];
      n4_q[i]    <= t3_q[i][20:16];
      z4_q[i]    <= (|t3_q[i][31:21]) || (t3_q[i][20:16] >= 5'd17);
      lik5_q[i]  <= z4_q[i] ? 17'd0 : (m_d[i] >> n4_q[i]);
      w6_q[i]    <= (tpc5_q && (i < Species)) ? (lik5_q[i] * prior_q[i]) : 33'd0;
      w7_q[i]    <= w6_q[i];
    end
    sum7_q <= sum_d;
  end

  // Restoring divider: one quotient bit per stage for every lane.
  logic [SumW:0]   r2_d [DivSteps][L];
  logic            ge_d [DivSteps][L];

  always_comb begin
    for (int s = 0; s < DivSteps; s++) begin
      for (int i = 0; i < L; i++) begin
        r2_d[s][i] = {rem_q[s][i], lq_q[s][i][15]};
        ge_d[s][i] = r2_d[s][i] >= {1'b0, dsum_q[s]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dsum_q[0] <= sum7_q;
    nop_q[0]  <= (sum7_q == '0);
    for (int i = 0; i < L; i++) begin
      rem_q[0][i] <= {{(SumW-33){1'b0}}, num_d[i][48:16]};
      lq_q[0][i]  <= num_d[i][15:0];
    end
    for (int s = 0; s < DivSteps; s++) begin
      dsum_q[s+1] <= dsum_q[s];
      nop_q[s+1]  <= nop_q[s];
      for (int i = 0; i < L; i++) begin
        rem_q[s+1][i] <= ge_d[s][i] ? SumW'(r2_d[s][i] - {1'b0, dsum_q[s]})
                                    : r2_d[s][i][SumW-1:0];
        lq_q[s+1][i]  <= {lq_q[s][i][14:0], ge_d[s][i]};
      end
    end
    // Output register; a zero sum forces all probabilities to zero.
    res_q.prob_pion      <= nop_q[DivSteps] ? 16'd0 : lq_q[DivSteps][0];
    res_q.prob_kaon      <= nop_q[DivSteps] ? 16'd0 : lq_q[DivSteps][1];
    res_q.prob_proton    <= nop_q[DivSteps] ? 16'd0 : lq_q[DivSteps][2];
    res_q.prob_electron  <= nop_q[DivSteps] ? 16'd0 : lq_q[DivSteps][3];
    res_q.no_probability <= nop_q[DivSteps];
  end

  assign done_o   = out_v_q;
  assign result_o = res_q;

  // A result strobe must be matched by an earlier accepted track.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, Latency))
    else $error("result without a matching accepted item");

  // A flagged result carries all-zero probabilities.
  a_noprob_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.no_probability |->
      (result_o.prob_pion == 16'd0) && (result_o.prob_kaon == 16'd0) &&
      (result_o.prob_proton == 16'd0) && (result_o.prob_electron == 16'd0))
    else $error("no_probability set with nonzero probabilities");

  // No probability exceeds one.
  a_prob_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.prob_pion <= 16'd32768) && (result_o.prob_kaon <= 16'd32768) &&
               (result_o.prob_proton <= 16'd32768) &&
               (result_o.prob_electron <= 16'd32768))
    else $error("probability above one");

endmodule

// ----- tb/sv/testbench.sv -----
// Testbench for bayesian_pid_track_classifier: directed table, then random tracks.
// Each accepted track is classified by a local predictor and compared with the strobed result.
// Depends on bpid_pkg and the classifier RTL.
`timescale 1ns / 1ps

module testbench;
  import bpid_pkg::*;

  localparam int unsigned PipeLatency = 26;
  localparam int unsigned DirRows     = 20;

  typedef struct packed {
    track_in_t  trk;
    logic       chk;
    track_out_t res;
  } dir_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  track_in_t           track_in_i;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [15:0]         cfg_data_i;
  logic                done_o;
  track_out_t          result_o;

  // Local copy of the configuration registers.
  logic [15:0] cut_reg [8];
  track_out_t  pending_probs [$];
  int          n_mismatch;
  dir_row_t    dir_tab [DirRows];

  bayesian_pid_track_classifier u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .track_in_i  (track_in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .done_o      (done_o),
    .result_o    (result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

  // Gaussian likelihood 2^-(chi2*log2e/2) in Q1.16.
  function automatic longint unsigned gauss_q16(input longint unsigned chi2);
    longint unsigned t, n, f, k, r, m, ta, tb;
    t = (chi2 * 94548) >> 17;
    n = t >> 16;
    f = t & 16'hFFFF;
    if (n >= 17) return 0;
    k  = f >> 12;
    r  = f & 12'hFFF;
    ta = (k == 0) ? 65536 : (k == 1) ? 62757 : (k == 2) ? 60097 : (k == 3) ? 57549 :
         (k == 4) ? 55109 : (k == 5) ? 52773 : (k == 6) ? 50535 : (k == 7) ? 48393 :
         (k == 8) ? 46341 : (k == 9) ? 44376 : (k == 10) ? 42494 : (k == 11) ? 40693 :
         (k == 12) ? 38968 : (k == 13) ? 37316 : (k == 14) ? 35734 : 34219;
    tb = (k == 0) ? 62757 : (k == 1) ? 60097 : (k == 2) ? 57549 : (k == 3) ? 55109 :
         (k == 4) ? 52773 : (k == 5) ? 50535 : (k == 6) ? 48393 : (k == 7) ? 46341 :
         (k == 8) ? 44376 : (k == 9) ? 42494 : (k == 10) ? 40693 : (k == 11) ? 38968 :
         (k == 12) ? 37316 : (k == 13) ? 35734 : (k == 14) ? 34219 : 32768;
    m = ta - (((ta - tb) * r) >> 12);
    return m >> n;
  endfunction

  // Classify one track; returns 0 when the track falls outside the cut window.
  function automatic bit classify_track(input track_in_t trk, output track_out_t res);
    longint unsigned w [4];
    longint unsigned total, chi2, p;
    logic signed [15:0] a, b;
    longint signed sa, sb;
    res = '0;
    total = 0;
    if (trk.track_pt < cut_reg[RegMinPt] || trk.track_pt > cut_reg[RegMaxPt]) return 0;
    if ($signed(trk.track_eta) < $signed(cut_reg[RegMinEta]) ||
        $signed(trk.track_eta) > $signed(cut_reg[RegMaxEta])) return 0;
    for (int i = 0; i < 4; i++) begin
      w[i] = 0;
      case (i)
        0: begin a = trk.tpc_sigma_pion;     b = trk.tof_sigma_pion;     end
        1: begin a = trk.tpc_sigma_kaon;     b = trk.tof_sigma_kaon;     end
        2: begin a = trk.tpc_sigma_proton;   b = trk.tof_sigma_proton;   end
        default: begin a = trk.tpc_sigma_electron; b = trk.tof_sigma_electron; end
      endcase
      if (trk.tpc_present && i < Species) begin
        sa = a;
        sb = b;
        chi2 = sa * sa;
        if (trk.tof_present) chi2 += sb * sb;
        w[i] = gauss_q16(chi2) * cut_reg[4 + i];
        total += w[i];
      end
    end
    for (int i = 0; i < 4; i++) begin
      p = (total != 0) ? (w[i] * 32768 + (total >> 1)) / total : 0;
      case (i)
        0: res.prob_pion     = p[15:0];
        1: res.prob_kaon     = p[15:0];
        2: res.prob_proton   = p[15:0];
        default: res.prob_electron = p[15:0];
      endcase
    end
    res.no_probability = (total == 0);
    return 1;
  endfunction

  // Compare each strobed result with the oldest expected one.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_probs.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result %h", result_o);
      end else begin
        track_out_t e;
        e = pending_probs.pop_front();
        if (result_o.prob_pion !== e.prob_pion || result_o.prob_kaon !== e.prob_kaon ||
            result_o.prob_proton !== e.prob_proton ||
            result_o.prob_electron !== e.prob_electron ||
            result_o.no_probability !== e.no_probability) begin
          n_mismatch++;
          if (n_mismatch <= 10) $display("mismatch: expected %h actual %h", e, result_o);
        end
      end
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cut_reg[idx] = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Send one track; optionally check against a typed-in result as well.
  task automatic send_track(input track_in_t trk, input bit gap_ok, input bit use_fixed,
                            input track_out_t fixed);
    track_out_t r;
    if (gap_ok) begin
      while ($urandom_range(99) < 16) begin
        @(posedge clk_i);
        start <= 1'b0;
      end
    end
    @(posedge clk_i);
    start      <= 1'b1;
    track_in_i <= trk;
    if (classify_track(trk, r)) begin
      if (use_fixed && r !== fixed) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("table row disagrees: %h vs %h", fixed, r);
      end
      pending_probs.push_back(r);
    end
    while (busy) @(posedge clk_i);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    @(posedge clk_i);
    start <= 1'b0;
    while (pending_probs.size() != 0 && guard < 10000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (PipeLatency + 4) @(posedge clk_i);
  endtask

  function automatic track_in_t rand_track(input bit formed);
    track_in_t t;
    t = track_in_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    if (formed) begin
      t.track_pt  = 16'($urandom_range(5200, 0));
      t.track_eta = $signed(16'($urandom_range(12800))) - 16'sd6400;
      t.tpc_present = ($urandom_range(9) != 0);
      t.tpc_sigma_pion     = $signed(16'($urandom_range(2048))) - 16'sd1024;
      t.tpc_sigma_kaon     = $signed(16'($urandom_range(2048))) - 16'sd1024;
      t.tpc_sigma_proton   = $signed(16'($urandom_range(2048))) - 16'sd1024;
      t.tpc_sigma_electron = $signed(16'($urandom_range(2048))) - 16'sd1024;
      t.tof_sigma_pion     = $signed(16'($urandom_range(2048))) - 16'sd1024;
      t.tof_sigma_kaon     = $signed(16'($urandom_range(2048))) - 16'sd1024;
    end
    return t;
  endfunction

  function automatic track_in_t base_track(input logic [15:0] pt, input logic [15:0] eta,
                                           input logic tpc, input logic tof,
                                           input logic [15:0] s);
    track_in_t t;
    t = '0;
    t.track_pt = pt;
    t.track_eta = eta;
    t.tpc_present = tpc;
    t.tof_present = tof;
    t.tpc_sigma_pion = s; t.tpc_sigma_kaon = s;
    t.tpc_sigma_proton = s; t.tpc_sigma_electron = s;
    t.tof_sigma_pion = s; t.tof_sigma_kaon = s;
    t.tof_sigma_proton = s; t.tof_sigma_electron = s;
    return t;
  endfunction

  initial begin
    track_out_t none_out;
    track_out_t tt;
    logic [15:0] v;
    start = 1'b0; track_in_i = '0; cfg_we_i = 1'b0; cfg_index_i = RegMinPt;
    cfg_data_i = '0; n_mismatch = 0; rst_ni = 1'b0;
    cut_reg[RegMinPt] = 16'd26;      cut_reg[RegMaxPt] = 16'd5120;
    cut_reg[RegMinEta] = 16'hE800;   cut_reg[RegMaxEta] = 16'd6144;
    cut_reg[RegPriorPion] = 16'd32768; cut_reg[RegPriorKaon] = 16'd6554;
    cut_reg[RegPriorProt] = 16'd3277;  cut_reg[RegPriorElec] = 16'd1638;
    none_out = '0;
    none_out.no_probability = 1'b1;
    tt = '0;

    // Directed rows: window edges, missing detectors, extreme n-sigma values.
    dir_tab[0]  = '{base_track(16'd26, 16'hE800, 1, 1, 16'd0), 1'b0, tt};
    dir_tab[1]  = '{base_track(16'd5120, 16'd6144, 1, 0, 16'd256), 1'b0, tt};
    dir_tab[2]  = '{base_track(16'd25, 16'd0, 1, 1, 16'd0), 1'b0, tt};
    dir_tab[3]  = '{base_track(16'd5121, 16'd0, 1, 1, 16'd0), 1'b0, tt};
    dir_tab[4]  = '{base_track(16'd100, 16'hE7FF, 1, 1, 16'd0), 1'b0, tt};
    dir_tab[5]  = '{base_track(16'd100, 16'd6145, 1, 1, 16'd0), 1'b0, tt};
    dir_tab[6]  = '{base_track(16'd100, 16'd0, 0, 1, 16'd0), 1'b1, none_out};
    dir_tab[7]  = '{base_track(16'd100, 16'd0, 1, 1, 16'h8000), 1'b1, none_out};
    dir_tab[8]  = '{base_track(16'd100, 16'd0, 1, 1, 16'h7FFF), 1'b1, none_out};
    dir_tab[9]  = '{base_track(16'd100, 16'd0, 1, 0, 16'h7FFF), 1'b1, none_out};
    dir_tab[10] = '{base_track(16'd100, 16'd0, 1, 0, 16'd0), 1'b0, tt};
    dir_tab[11] = '{base_track(16'd100, 16'd0, 1, 1, 16'hFC19), 1'b0, tt};
    dir_tab[12] = '{base_track(16'd100, 16'd0, 1, 0, 16'hFF00), 1'b0, tt};
    dir_tab[13] = '{base_track(16'hFFFF, 16'h7FFF, 1, 1, 16'd0), 1'b0, tt};
    dir_tab[14] = '{base_track(16'd0, 16'h8000, 1, 1, 16'd0), 1'b0, tt};
    for (int i = 15; i < DirRows; i++)
      dir_tab[i] = '{rand_track(1), 1'b0, tt};
    dir_tab[15].trk.tof_sigma_proton = 16'hFC19;   // absent TOF sentinel ignored
    dir_tab[15].trk.tof_present = 1'b0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (dir_tab[i]) send_track(dir_tab[i].trk, 1'b0, dir_tab[i].chk, dir_tab[i].res);
    drain();

    // Phases of random tracks under several register settings.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1: begin
          write_reg(RegMinPt, 16'd0);       write_reg(RegMaxPt, 16'hFFFF);
          write_reg(RegMinEta, 16'h8000);   write_reg(RegMaxEta, 16'h7FFF);
          write_reg(RegPriorPion, 16'hFFFF); write_reg(RegPriorKaon, 16'd0);
          write_reg(RegPriorProt, 16'd32768); write_reg(RegPriorElec, 16'd1);
        end
        2: begin
          write_reg(RegPriorPion, 16'd0); write_reg(RegPriorKaon, 16'd0);
          write_reg(RegPriorProt, 16'd0); write_reg(RegPriorElec, 16'd0);
        end
        3: begin
          write_reg(RegMinPt, 16'd3000); write_reg(RegMaxPt, 16'd1000);
        end
        4: begin
          write_reg(RegMinPt, 16'd500);    write_reg(RegMaxPt, 16'd4000);
          write_reg(RegMinEta, 16'd100);   write_reg(RegMaxEta, 16'hFF00);
        end
        5: begin
          write_reg(RegMinEta, 16'hF000); write_reg(RegMaxEta, 16'd4096);
          for (int r = 4; r < 8; r++) begin
            v = 16'($urandom_range(32768));
            write_reg(r[CfgIdxW-1:0], v);
          end
        end
        default: ;
      endcase
      for (int n = 0; n < 85; n++)
        send_track(rand_track($urandom_range(9) != 0), (ph != 2), 1'b0, tt);
      drain();
    end

    if (n_mismatch == 0 && pending_probs.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
